// ----- sv/tcaof_pkg.sv -----
package tcaof_pkg;

  // Fixed field widths
  localparam int ACT_W   = 3;
  localparam int ID_W    = 16;
  localparam int STAMP_W = 32;
  localparam int STAT_W  = 2;

  // Default depth of each class queue
  localparam int QUEUE_DEPTH_DEF = 16;

  // Request codes; codes above ACT_GET_OLD mean nothing
  typedef enum logic [ACT_W-1:0] {
    ACT_PUT_A   = 3'd0,
    ACT_PUT_B   = 3'd1,
    ACT_GET_A   = 3'd2,
    ACT_GET_B   = 3'd3,
    ACT_GET_OLD = 3'd4
  } action_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One stored entry: identifier and arrival stamp
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Controls from the top level into one class queue
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t wdata;
  } queue_ctl_t;

  // Status from one class queue back to the top level
  typedef struct packed {
    logic   empty;
    logic   full;
    entry_t head;
  } queue_sts_t;

endpackage

// ----- sv/tcaof_if.sv -----
// Request channel
interface tcaof_in_if;
  import tcaof_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACT_W-1:0]     action;
  logic [ID_W-1:0]      item_id;

  modport source (output valid, output action, output item_id, input ready);
  modport sink   (input valid, input action, input item_id, output ready);
endinterface

// Result channel
interface tcaof_out_if;
  import tcaof_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [ID_W-1:0]      out_item;
  logic                 out_class;
  logic [STAMP_W-1:0]   out_stamp;

  modport source (output valid, output status, output out_item, output out_class,
                  output out_stamp, input ready);
  modport sink   (input valid, input status, input out_item, input out_class,
                  input out_stamp, output ready);
endinterface

// ----- sv/tcaof_queue.sv -----
// One class queue: circular buffer in a memory with a prefetched head entry.
module tcaof_queue #(
  parameter int DEPTH = tcaof_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tcaof_pkg::queue_ctl_t  ctl,
  output tcaof_pkg::queue_sts_t  sts
);
  import tcaof_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [AW-1:0]   head_r;
  logic [AW-1:0]   head_nxt;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic [AW:0]     tail_sum;
  logic [AW-1:0]   tail;
  entry_t          rd_q_r;
  logic            byp_r;
  logic            byp_nxt;
  entry_t          byp_data_r;

  // Tail address = (head + count) mod DEPTH, sum stays below 2*DEPTH
  always_comb begin
    tail_sum = {1'b0, head_r} + (AW+1)'(count_r);
    if (tail_sum >= (AW+1)'(DEPTH)) begin
      tail = AW'(tail_sum - (AW+1)'(DEPTH));
    end else begin
      tail = AW'(tail_sum);
    end
  end

  // Pointer and occupancy updates
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctl.pop) begin
      head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
      count_nxt = count_r - CW'(1);
    end else if (ctl.push) begin
      count_nxt = count_r + CW'(1);
    end
  end

  // A push into an empty queue lands on the head slot being read
  assign byp_nxt = ctl.push && (tail == head_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      byp_r   <= byp_nxt;
    end
  end

  // Storage: one write port at the tail, registered read of the next head
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= ctl.wdata;
    end
    rd_q_r     <= mem[head_nxt];
    byp_data_r <= ctl.wdata;
  end

  // Status back to the controller
  always_comb begin
    sts.empty = (count_r == '0);
    sts.full  = (count_r == CW'(DEPTH));
    sts.head  = byp_r ? byp_data_r : rd_q_r;
  end

endmodule

// ----- sv/two_class_age_ordered_fifo_top.sv -----
// Two-class age-ordered FIFO. Requests put an identifier into class A or B,
// get the head of one class, or get the older of the two heads. Every put
// that is taken is stamped from a shared 32-bit arrival counter (first stamp
// after reset is 1); the oldest-get compares head stamps by wrapped
// difference, valid while the two head stamps are under 2^31 apart, and
// picks A on a tie. A put to a full class is dropped with status full and
// uses no stamp; a get from an empty class returns status empty. Each
// request gives exactly one result transaction. One request is taken per
// clock: the request register feeds the queue heads and counters directly,
// and the result register is loaded from them when the request moves on,
// so throughput is one transaction per cycle; only a stalled result channel
// holds the input off. Each class queue is QUEUE_DEPTH entries in a
// memory with a prefetched head entry; no clearing pass is needed after reset.
module two_class_age_ordered_fifo_top #(
  parameter int QUEUE_DEPTH = tcaof_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  tcaof_in_if.sink          in_chan,
  tcaof_out_if.source       out_chan
);
  import tcaof_pkg::*;

  // Request register
  logic               in_v_r;
  logic [ACT_W-1:0]   in_act_r;
  logic [ID_W-1:0]    in_id_r;

  // Result register
  logic               out_v_r;
  status_t            st_r;
  logic [ID_W-1:0]    item_r;
  logic               cls_r;
  logic [STAMP_W-1:0] stamp_r;

  logic [STAMP_W-1:0] counter_r;
  logic [STAMP_W-1:0] stamp_new;
  logic [STAMP_W-1:0] diff;

  logic               proc;
  logic               cnt_inc;
  status_t            res_st;
  logic [ID_W-1:0]    res_item;
  logic               res_cls;
  logic [STAMP_W-1:0] res_stamp;
  logic               pick_b;

  queue_ctl_t         ctl_a;
  queue_ctl_t         ctl_b;
  queue_sts_t         sts_a;
  queue_sts_t         sts_b;

  // Handshake: the request moves on when the result slot is free or draining
  assign proc          = in_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready = !in_v_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_act_r <= in_chan.action;
      in_id_r  <= in_chan.item_id;
    end
  end

  // Class queues
  tcaof_queue #(.DEPTH(QUEUE_DEPTH)) u_queue_a (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_a),
    .sts   (sts_a)
  );

  tcaof_queue #(.DEPTH(QUEUE_DEPTH)) u_queue_b (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_b),
    .sts   (sts_b)
  );

  // Stamp for a put, and age order of the two heads
  assign stamp_new = counter_r + STAMP_W'(1);
  assign diff      = sts_b.head.stamp - sts_a.head.stamp;
  assign pick_b    = sts_a.empty || (!sts_b.empty && diff[STAMP_W-1]);

  // Request decode and result formation
  always_comb begin
    ctl_a       = '0;
    ctl_b       = '0;
    ctl_a.wdata = '{id: in_id_r, stamp: stamp_new};
    ctl_b.wdata = '{id: in_id_r, stamp: stamp_new};
    cnt_inc     = 1'b0;
    res_st      = ST_EMPTY;
    res_item    = '0;
    res_cls     = 1'b0;
    res_stamp   = '0;
    unique case (action_t'(in_act_r))
      ACT_PUT_A: begin
        res_item = in_id_r;
        if (sts_a.full) begin
          res_st = ST_FULL;
        end else begin
          res_st     = ST_OK;
          res_stamp  = stamp_new;
          ctl_a.push = proc;
          cnt_inc    = proc;
        end
      end
      ACT_PUT_B: begin
        res_item = in_id_r;
        res_cls  = 1'b1;
        if (sts_b.full) begin
          res_st = ST_FULL;
        end else begin
          res_st     = ST_OK;
          res_stamp  = stamp_new;
          ctl_b.push = proc;
          cnt_inc    = proc;
        end
      end
      ACT_GET_A: begin
        if (!sts_a.empty) begin
          res_st    = ST_OK;
          res_item  = sts_a.head.id;
          res_stamp = sts_a.head.stamp;
          ctl_a.pop = proc;
        end
      end
      ACT_GET_B: begin
        res_cls = 1'b1;
        if (!sts_b.empty) begin
          res_st    = ST_OK;
          res_item  = sts_b.head.id;
          res_stamp = sts_b.head.stamp;
          ctl_b.pop = proc;
        end
      end
      ACT_GET_OLD: begin
        if (!(sts_a.empty && sts_b.empty)) begin
          res_st = ST_OK;
          if (pick_b) begin
            res_cls   = 1'b1;
            res_item  = sts_b.head.id;
            res_stamp = sts_b.head.stamp;
            ctl_b.pop = proc;
          end else begin
            res_item  = sts_a.head.id;
            res_stamp = sts_a.head.stamp;
            ctl_a.pop = proc;
          end
        end
      end
      default: begin
        res_st = ST_EMPTY;
      end
    endcase
  end

  // Arrival counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
    end else if (cnt_inc) begin
      counter_r <= stamp_new;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      st_r    <= res_st;
      item_r  <= res_item;
      cls_r   <= res_cls;
      stamp_r <= res_stamp;
    end
  end

  assign out_chan.valid     = out_v_r;
  assign out_chan.status    = st_r;
  assign out_chan.out_item  = item_r;
  assign out_chan.out_class = cls_r;
  assign out_chan.out_stamp = stamp_r;

endmodule
